// ===== src/block_bitmap_allocator_defines.svh =====
// Assertion macros for the block bitmap allocator.
// Used by the top level; expects clk and rst in scope.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// next-cycle implication, disabled in reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

// ===== src/bba_pkg.sv =====
// Shared types, codes and sizes of the block bitmap allocator.
// No dependencies.
`default_nettype none
package bba_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int INDEX_W = 12;
  localparam int COUNT_W = 13;
  localparam int WORD_W = 64;
  localparam int WORD_AW = $clog2(WORD_W);
  localparam int NUM_WORDS = NUM_BLOCKS / WORD_W;
  localparam int WADDR_W = $clog2(NUM_WORDS);
  localparam logic [COUNT_W-1:0] DATA_START_RESET = 13'd82;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_MARK = 2'd1;
  localparam logic [1:0] MODE_FREE = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NONE_FREE = 3'd1;
  localparam logic [2:0] ST_RESERVED = 3'd2;
  localparam logic [2:0] ST_NOT_USED = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [INDEX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [INDEX_W-1:0] result_index;
    logic [COUNT_W-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
    logic load;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/block_bitmap_allocator.sv =====
// Top level of the block bitmap allocator: sequencer plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp and block_bitmap_allocator_defines.svh.
//
// First-fit allocator over 4096 blocks held as 64 words of 64 bits. Each item
// passes accept, word read, read-modify-write and output load; the load waits
// while the result register is stalled, and no new item is accepted before it.
// The single-port bitmap word memory is read and written once per item.
// Allocation picks the lowest non-full word from a per-word full summary, then
// the lowest zero bit of that word. Reset clears the map at once through
// per-word valid bits, so no clearing pass runs. The data_start register is
// always ready, to be written by the user only while idle; it is not enforced.
`default_nettype none
`include "block_bitmap_allocator_defines.svh"
module block_bitmap_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire bba_pkg::req_t                req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output bba_pkg::rsp_t                     rsp,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bba_pkg::COUNT_W-1:0]  cfg_data
);

  bba_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .rsp      (rsp),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

  `BBA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `BBA_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))
  `BBA_ASSERT_SAME(a_none_free_empty, rsp_valid && rsp.status == bba_pkg::ST_NONE_FREE,
                   rsp.free_count == '0)

endmodule
`default_nettype wire

// ===== src/bba_ctrl.sv =====
// Sequencer of the block bitmap allocator: accept, read, update, deliver.
// Depends on bba_pkg.
`default_nettype none
module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bba_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;
  logic       out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    rsp_valid_next = rsp_valid && rsp_stall;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load = 1'b1;
          rsp_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/bba_dp.sv =====
// Datapath of the block bitmap allocator: word-wide bitmap memory, row valid
// and full summaries, free count, reserved start and result registers.
// Depends on bba_pkg.
`default_nettype none
module bba_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bba_pkg::cmd_t                 cmd,
  input  wire bba_pkg::req_t                 req,
  output bba_pkg::rsp_t                      rsp,
  input  wire logic                          cfg_we,
  input  wire logic [bba_pkg::COUNT_W-1:0]   cfg_data
);

  logic [bba_pkg::WORD_W-1:0]    mem [bba_pkg::NUM_WORDS];
  logic [bba_pkg::NUM_WORDS-1:0] row_valid;
  logic [bba_pkg::NUM_WORDS-1:0] full;
  logic [bba_pkg::COUNT_W-1:0]   count;
  logic [bba_pkg::COUNT_W-1:0]   data_start;
  logic [1:0]                    mode_r;
  logic [bba_pkg::INDEX_W-1:0]   idx_r;
  logic [bba_pkg::WADDR_W-1:0]   waddr;
  logic [bba_pkg::WADDR_W-1:0]   waddr_next;
  logic [bba_pkg::WORD_W-1:0]    rd_word;
  bba_pkg::rsp_t                 res;

  logic [bba_pkg::WORD_W-1:0]    word_eff;
  logic [bba_pkg::WORD_W-1:0]    word_next;
  logic [bba_pkg::WORD_AW-1:0]   bpos;
  logic [bba_pkg::WORD_AW-1:0]   boff;
  logic [bba_pkg::COUNT_W-1:0]   count_next;
  logic [2:0]                    status;
  logic [bba_pkg::INDEX_W-1:0]   res_index;
  logic                          bit_used;
  logic                          out_of_range;

  // lowest word that still has a free block for an allocate, else the word of the block index
  always_comb begin
    waddr_next = req.block_index[bba_pkg::WORD_AW +: bba_pkg::WADDR_W];
    if (req.mode == bba_pkg::MODE_ALLOC) begin
      waddr_next = '0;
      for (int i = bba_pkg::NUM_WORDS - 1; i >= 0; i--) begin
        if (!full[i]) waddr_next = bba_pkg::WADDR_W'(i);
      end
    end
  end

  // lowest free bit in the word read back
  always_comb begin
    bpos = '0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word_eff[i]) bpos = bba_pkg::WORD_AW'(i);
    end
  end

  assign word_eff = row_valid[waddr] ? rd_word : '0;
  assign boff = idx_r[bba_pkg::WORD_AW-1:0];
  assign bit_used = word_eff[boff];
  assign out_of_range = ({1'b0, idx_r} >= bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS));

  always_comb begin
    word_next = word_eff;
    count_next = count;
    status = bba_pkg::ST_OK;
    res_index = idx_r;
    case (mode_r)
      bba_pkg::MODE_ALLOC: begin
        if (count == '0) begin
          status = bba_pkg::ST_NONE_FREE;
          res_index = '0;
        end else begin
          word_next = word_eff | (bba_pkg::WORD_W'(1) << bpos);
          count_next = count - 1'b1;
          res_index = bba_pkg::INDEX_W'({waddr, bpos});
        end
      end
      bba_pkg::MODE_MARK: begin
        if (out_of_range) begin
          status = bba_pkg::ST_RANGE;
        end else begin
          word_next = word_eff | (bba_pkg::WORD_W'(1) << boff);
          if (!bit_used && count != '0) count_next = count - 1'b1;
        end
      end
      bba_pkg::MODE_FREE: begin
        if (out_of_range) begin
          status = bba_pkg::ST_RANGE;
        end else if ({1'b0, idx_r} < data_start) begin
          status = bba_pkg::ST_RESERVED;
        end else if (!bit_used) begin
          status = bba_pkg::ST_NOT_USED;
        end else begin
          word_next = word_eff & ~(bba_pkg::WORD_W'(1) << boff);
          count_next = count + 1'b1;
        end
      end
      default: begin
        status = bba_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.read) rd_word <= mem[waddr];
    if (cmd.exec) mem[waddr] <= word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      full <= '0;
      count <= bba_pkg::COUNT_W'(bba_pkg::NUM_BLOCKS);
      data_start <= bba_pkg::DATA_START_RESET;
    end else begin
      if (cfg_we) data_start <= cfg_data;
      if (cmd.exec) begin
        row_valid[waddr] <= 1'b1;
        full[waddr] <= &word_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= req.mode;
      idx_r <= req.block_index;
      waddr <= waddr_next;
    end
    if (cmd.exec) begin
      res.status <= status;
      res.result_index <= res_index;
      res.free_count <= count_next;
    end
    if (cmd.load) rsp <= res;
  end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for block_bitmap_allocator: random and directed allocate,
// mark, free and no-op items, checked against an in-bench bitmap predictor.
// Depends on bba_pkg and the block_bitmap_allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bba_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bba_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bba_pkg::COUNT_W-1:0] cfg_data = '0;

  block_bitmap_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic blk_used [bba_pkg::NUM_BLOCKS];
  int unsigned free_left;
  logic [bba_pkg::COUNT_W-1:0] ds_model;

  bba_pkg::req_t req_backlog [$];
  bba_pkg::rsp_t rsp_expected [$];
  bba_pkg::rsp_t want;
  int n_items = 0;
  int n_results = 0;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bba_pkg::rsp_t apply_request(bba_pkg::req_t r);
    bba_pkg::rsp_t o;
    int unsigned idx;
    int i;
    logic found;
    o.status = bba_pkg::ST_OK;
    o.result_index = r.block_index;
    idx = r.block_index;
    case (r.mode)
      bba_pkg::MODE_ALLOC: begin
        o.status = bba_pkg::ST_NONE_FREE;
        o.result_index = '0;
        found = 1'b0;
        i = 0;
        if (free_left != 0) begin
          while (!found && i < bba_pkg::NUM_BLOCKS) begin
            if (!blk_used[i]) begin
              blk_used[i] = 1'b1;
              free_left--;
              o.status = bba_pkg::ST_OK;
              o.result_index = i[bba_pkg::INDEX_W-1:0];
              found = 1'b1;
            end
            i++;
          end
        end
      end
      bba_pkg::MODE_MARK: begin
        if (idx >= bba_pkg::NUM_BLOCKS) begin
          o.status = bba_pkg::ST_RANGE;
        end else if (!blk_used[idx]) begin
          blk_used[idx] = 1'b1;
          if (free_left > 0) free_left--;
        end
      end
      bba_pkg::MODE_FREE: begin
        if (idx >= bba_pkg::NUM_BLOCKS) begin
          o.status = bba_pkg::ST_RANGE;
        end else if (idx < ds_model) begin
          o.status = bba_pkg::ST_RESERVED;
        end else if (!blk_used[idx]) begin
          o.status = bba_pkg::ST_NOT_USED;
        end else begin
          blk_used[idx] = 1'b0;
          free_left++;
        end
      end
      default: begin
      end
    endcase
    o.free_count = free_left[bba_pkg::COUNT_W-1:0];
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) rsp_expected.push_back(apply_request(req));
      if (!req_valid || !req_stall) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_left <= HOLD_CYCLES;
        hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_req && !hold_taken) || hold_left > 1 ||
                   ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      n_results++;
      if (rsp_expected.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, rsp);
        errors++;
      end else begin
        want = rsp_expected.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("result_index", want.result_index, rsp.result_index);
        check_field("free_count", want.free_count, rsp.free_count);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** block_bitmap_allocator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(logic [1:0] m, int unsigned idx);
    bba_pkg::req_t r;
    r.mode = m;
    r.block_index = idx[bba_pkg::INDEX_W-1:0];
    req_backlog.push_back(r);
    n_items++;
  endtask

  task automatic add_random(int count);
    int sel;
    int unsigned idx;
    int lo;
    int hi;
    logic [1:0] m;
    repeat (count) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        idx = $urandom_range(0, 255);
      end else if (sel < 7) begin
        lo = (ds_model > 32) ? int'(ds_model) - 32 : 0;
        hi = (int'(ds_model) + 32 < bba_pkg::NUM_BLOCKS) ? int'(ds_model) + 32 :
             bba_pkg::NUM_BLOCKS - 1;
        if (lo > hi) lo = hi;
        idx = $urandom_range(lo, hi);
      end else begin
        idx = $urandom_range(0, bba_pkg::NUM_BLOCKS - 1);
      end
      sel = $urandom_range(0, 19);
      if (sel < 7) m = bba_pkg::MODE_ALLOC;
      else if (sel < 11) m = bba_pkg::MODE_MARK;
      else if (sel < 19) m = bba_pkg::MODE_FREE;
      else m = MODE_NOP;
      add_item(m, idx);
    end
  endtask

  task automatic wait_idle();
    wait (n_results >= n_items);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_data_start(logic [bba_pkg::COUNT_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ds_model = v;
  endtask

  task automatic set_pace(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    for (int i = 0; i < bba_pkg::NUM_BLOCKS; i++) blk_used[i] = 1'b0;
    free_left = bba_pkg::NUM_BLOCKS;
    ds_model = bba_pkg::DATA_START_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset value of data_start
    add_item(bba_pkg::MODE_ALLOC, 0);
    add_item(bba_pkg::MODE_ALLOC, 12'hFFF);
    add_item(bba_pkg::MODE_FREE, 0);
    add_item(bba_pkg::MODE_FREE, 81);
    add_item(bba_pkg::MODE_FREE, 82);
    add_item(bba_pkg::MODE_MARK, 82);
    add_item(bba_pkg::MODE_MARK, 82);
    add_item(bba_pkg::MODE_FREE, 82);
    add_item(bba_pkg::MODE_ALLOC, 0);
    add_item(bba_pkg::MODE_MARK, 4095);
    add_item(bba_pkg::MODE_FREE, 4095);
    add_item(bba_pkg::MODE_FREE, 4095);
    add_item(bba_pkg::MODE_MARK, 2048);
    add_item(bba_pkg::MODE_FREE, 2048);
    add_item(bba_pkg::MODE_MARK, 12'hAAA);
    add_item(bba_pkg::MODE_MARK, 12'h555);
    add_item(bba_pkg::MODE_FREE, 12'hAAA);
    add_item(bba_pkg::MODE_FREE, 12'h555);
    add_item(MODE_NOP, 12'hFFF);
    add_item(MODE_NOP, 0);
    add_item(bba_pkg::MODE_ALLOC, 0);

    // no reserved blocks: block 0 may be freed and reallocated
    write_data_start(13'd0);
    add_item(bba_pkg::MODE_FREE, 0);
    add_item(bba_pkg::MODE_ALLOC, 0);
    add_item(bba_pkg::MODE_FREE, 4095);
    add_item(bba_pkg::MODE_MARK, 4095);
    add_item(bba_pkg::MODE_FREE, 4095);
    add_item(bba_pkg::MODE_ALLOC, 0);

    write_data_start(13'd4096);
    set_pace(7, 7);
    add_random(60);

    write_data_start(13'd1);
    set_pace(79, 0);
    add_random(200);

    write_data_start(13'd4095);
    set_pace(0, 79);
    add_random(150);

    write_data_start(bba_pkg::COUNT_W'($urandom_range(2, 300)));
    set_pace(7, 7);
    add_random(200);

    // long receiver hold-off while the sender keeps offering items
    write_data_start(bba_pkg::DATA_START_RESET);
    set_pace(0, 0);
    hold_req <= 1'b1;
    add_random(150);

    wait (n_results >= n_items);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rsp_expected.size() != 0) begin
      $display("%0t: %0d results missing, next expected %p, actual none",
               $time, rsp_expected.size(), rsp_expected[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("** block_bitmap_allocator: PASSED **");
    end else begin
      $display("** block_bitmap_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bba_pkg.sv
src/bba_ctrl.sv
src/bba_dp.sv
src/block_bitmap_allocator.sv
verif/tb_top.sv
